FILE: design/dgtw_pkg.sv
package dgtw_pkg;

  localparam int GRID_X = 16;
  localparam int GRID_Y = 16;
  localparam int GRID_Z = 16;
  localparam int MEM_DEPTH = 4096;
  localparam int ADDR_W = 12;
  localparam logic signed [48:0] INTER_SAT = 49'sd140737488355327;
  localparam int BLEND_CYC = 6;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_INV_X    = 3'd3;
  localparam logic [2:0] REG_INV_Y    = 3'd4;
  localparam logic [2:0] REG_INV_Z    = 3'd5;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_WARP  = 1'b1;

  typedef struct packed {
    logic               func;
    logic [11:0]        cp_index;
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] warped_x;
    logic signed [31:0] warped_y;
    logic signed [31:0] warped_z;
    logic               outside_grid;
  } out_item_t;

  function automatic logic signed [48:0] sat49(input logic signed [50:0] v);
    if (v > 51'(INTER_SAT)) return INTER_SAT;
    if (v < -51'(INTER_SAT)) return -INTER_SAT;
    return v[48:0];
  endfunction

endpackage

FILE: design/dgtw_blend.sv
// a + f*(b-a)/65536, saturated; product from four 25x25 partial products,
// accumulated one per step, then the result is registered in y
module dgtw_blend (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [48:0]  a,
  input  logic signed [48:0]  b,
  input  logic signed [48:0]  f,
  output logic signed [48:0]  y
);
  import dgtw_pkg::*;

  logic signed [49:0] d;
  logic        [49:0] md;
  logic        [49:0] mf;
  logic signed [48:0] a_q;
  logic        [49:0] md_q;
  logic        [49:0] mf_q;
  logic               neg_q;
  logic         [2:0] step;
  logic        [24:0] op_m;
  logic        [24:0] op_f;
  logic        [49:0] pp;
  logic        [98:0] pp_sh;
  logic        [98:0] acc;
  logic        [82:0] sh;
  logic signed [49:0] t;

  always_comb begin
    d = 50'(b) - 50'(a);
    md = d[49] ? 50'(-d) : 50'(d);
    mf = f[48] ? 50'(-50'(f)) : 50'(f);
  end

  always_ff @(posedge clk) begin
    if (rst) step <= '0;
    else if (start) step <= 3'd1;
    else if (step == 3'd5) step <= '0;
    else if (step != 3'd0) step <= step + 3'd1;
  end

  always_comb begin
    unique case (step)
      3'd1: begin op_m = md_q[24:0];  op_f = mf_q[24:0];  end
      3'd2: begin op_m = md_q[24:0];  op_f = mf_q[49:25]; end
      3'd3: begin op_m = md_q[49:25]; op_f = mf_q[24:0];  end
      3'd4: begin op_m = md_q[49:25]; op_f = mf_q[49:25]; end
      default: begin op_m = '0; op_f = '0; end
    endcase
    pp = 50'(op_m) * 50'(op_f);
    unique case (step)
      3'd1: pp_sh = 99'(pp);
      3'd2, 3'd3: pp_sh = 99'(pp) << 25;
      3'd4: pp_sh = 99'(pp) << 50;
      default: pp_sh = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      md_q <= md;
      mf_q <= mf;
      neg_q <= d[49] != f[48];
      acc <= '0;
    end else if (step != 3'd0 && step != 3'd5) begin
      acc <= acc + pp_sh;
    end
    if (step == 3'd5) y <= sat49(51'(a_q) + 51'(t));
  end

  always_comb begin
    sh = acc[98:16];
    if (sh > 83'(INTER_SAT)) t = 50'(INTER_SAT);
    else t = 50'(sh[48:0]);
    if (neg_q) t = -t;
  end
endmodule

FILE: design/displacement_grid_trilinear_warp.sv
// channel | direction | payload    | handshake
// in      | input     | in_item_t  | in_valid / in_stall
// out     | output    | out_item_t | out_valid / out_stall
// cfg     | input     | 32-bit APB | psel/penable/pwrite, pready high
// A write item is stored on accept. A warp result passes mapping (S_MAP, S_IDX),
// the eight corner reads (one per cycle), three blend levels, and is loaded into
// the output register in S_DONE, after which the block returns to idle.
// Reset clears control and the origins, sets inverse spacings to 16777216; field memories stay undefined.
// A stalled result holds in the output register and stalls the input.
module displacement_grid_trilinear_warp (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dgtw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dgtw_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import dgtw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAP  = 3'd1;
  localparam logic [2:0] S_IDX  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_BLND = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [31:0] origin [3];
  logic [31:0] inv_sp [3];
  logic [2:0] state;
  logic [4:0] cnt;
  logic [2:0] reg_idx;

  logic [31:0] mem_x [MEM_DEPTH];
  logic [31:0] mem_y [MEM_DEPTH];
  logic [31:0] mem_z [MEM_DEPTH];
  logic [31:0] rd_x, rd_y, rd_z;
  logic [ADDR_W-1:0] rd_addr;

  logic signed [31:0] pos [3];
  logic signed [32:0] diff [3];
  logic        [64:0] mr [3];
  logic               outside;
  logic         [7:0] idx [3];
  logic signed [48:0] frac [3];
  logic [ADDR_W-1:0]  base;
  logic signed [48:0] corner [3][8];
  logic               accept;
  logic               bl_row;
  logic               bl_pl;
  logic               bl_z;
  logic signed [48:0] row [3][4];
  logic signed [48:0] plane [3][2];
  logic signed [48:0] res [3];

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;

  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X: prdata = origin[0];
      REG_ORIGIN_Y: prdata = origin[1];
      REG_ORIGIN_Z: prdata = origin[2];
      REG_INV_X:    prdata = inv_sp[0];
      REG_INV_Y:    prdata = inv_sp[1];
      REG_INV_Z:    prdata = inv_sp[2];
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        origin[i] <= '0;
        inv_sp[i] <= 32'd16777216;
      end
    end else if (psel && penable && pwrite) begin
      if (reg_idx < 3'd3) origin[reg_idx[1:0]] <= pwdata;
      else if (reg_idx < 3'd6) inv_sp[2'(reg_idx - 3'd3)] <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.func == FUNC_WRITE) begin
      mem_x[in_data.cp_index] <= in_data.disp_x;
      mem_y[in_data.cp_index] <= in_data.disp_y;
      mem_z[in_data.cp_index] <= in_data.disp_z;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
    rd_z <= mem_z[rd_addr];
  end

  localparam int SY = GRID_X;
  localparam int SZ = GRID_X * GRID_Y;
  always_comb begin
    logic [ADDR_W-1:0] off;
    off = ADDR_W'(cnt[0]) + (cnt[1] ? ADDR_W'(SY) : '0) + (cnt[2] ? ADDR_W'(SZ) : '0);
    rd_addr = base + off;
  end

  localparam int GD [3] = '{GRID_X, GRID_Y, GRID_Z};

  always_ff @(posedge clk) begin
    if (accept) begin
      pos[0] <= in_data.pos_x;
      pos[1] <= in_data.pos_y;
      pos[2] <= in_data.pos_z;
    end
    if (state == S_MAP) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [32:0] dd;
        logic [32:0] md;
        dd = 33'(pos[i]) - 33'(signed'(origin[i]));
        md = dd[32] ? 33'(-dd) : 33'(dd);
        diff[i] <= dd;
        mr[i] <= 65'(md) * 65'(inv_sp[i]);
      end
    end
    if (state == S_IDX) begin
      logic o;
      o = 1'b0;
      for (int i = 0; i < 3; i++) begin
        logic [40:0] r;
        logic [24:0] t;
        logic [7:0] ix;
        r = mr[i][64:24];
        t = r[40:16];
        if (diff[i][32] && r != 0) begin
          ix = '0; o = 1'b1;
          frac[i] <= -49'(r);
        end else begin
          ix = (t > 25'(GD[i] - 2)) ? 8'(GD[i] - 2) : t[7:0];
          if (r > (41'(GD[i] - 1) << 16)) o = 1'b1;
          frac[i] <= 49'(r) - (49'(ix) << 16);
        end
        idx[i] <= ix;
      end
      outside <= o;
    end
    if (state == S_READ && cnt != 0) begin
      corner[0][3'(cnt - 5'd1)] <= 49'(signed'(rd_x));
      corner[1][3'(cnt - 5'd1)] <= 49'(signed'(rd_y));
      corner[2][3'(cnt - 5'd1)] <= 49'(signed'(rd_z));
    end
  end

  always_comb begin
    logic [ADDR_W+16:0] b;
    b = 29'(idx[0]) + 29'(GRID_X) * (29'(idx[1]) + 29'(GRID_Y) * 29'(idx[2]));
    base = b[ADDR_W-1:0];
  end

  assign bl_row = (state == S_BLND) && (cnt == 5'd0);
  assign bl_pl  = (state == S_BLND) && (cnt == 5'(BLEND_CYC));
  assign bl_z   = (state == S_BLND) && (cnt == 5'(2 * BLEND_CYC));

  for (genvar c = 0; c < 3; c++) begin : g_ch
    for (genvar r = 0; r < 4; r++) begin : g_row
      dgtw_blend u_r (.clk, .rst, .start(bl_row), .a(corner[c][2*r]),
                      .b(corner[c][2*r+1]), .f(frac[0]), .y(row[c][r]));
    end
    for (genvar p = 0; p < 2; p++) begin : g_pl
      dgtw_blend u_p (.clk, .rst, .start(bl_pl), .a(row[c][2*p]), .b(row[c][2*p+1]),
                      .f(frac[1]), .y(plane[c][p]));
    end
    dgtw_blend u_z (.clk, .rst, .start(bl_z), .a(plane[c][0]), .b(plane[c][1]),
                    .f(frac[2]), .y(res[c]));
  end

  function automatic logic [31:0] sat32(input logic signed [31:0] p,
                                        input logic signed [48:0] v);
    logic signed [49:0] s;
    s = 50'(p) + 50'(v);
    if (s > 50'sd2147483647) return 32'h7fffffff;
    if (s < -50'sd2147483648) return 32'h80000000;
    return s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && !(out_valid && out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept && in_data.func == FUNC_WARP) state <= S_MAP;
        S_MAP:  state <= S_IDX;
        S_IDX: begin
          state <= S_READ; cnt <= '0;
        end
        S_READ: begin
          if (cnt == 5'd8) begin
            state <= S_BLND; cnt <= '0;
          end else cnt <= cnt + 5'd1;
        end
        S_BLND: begin
          if (cnt == 5'(3 * BLEND_CYC - 1)) state <= S_DONE;
          else cnt <= cnt + 5'd1;
        end
        S_DONE: if (!(out_valid && out_stall)) begin
          out_data.warped_x <= sat32(pos[0], res[0]);
          out_data.warped_y <= sat32(pos[1], res[1]);
          out_data.warped_z <= sat32(pos[2], res[2]);
          out_data.outside_grid <= outside;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !accept) else $error("item taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result lost");
  a_done_from_blend: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> ($past(state) == S_BLND || $past(state) == S_DONE))
    else $error("bad sequence");
endmodule
